>>> rtl/core/sam_pkg.sv
`default_nettype none

package sam_pkg;

    localparam int HEIGHT_BITS_DEF = 16;

    // register map, byte address 4*index
    typedef enum logic [2:0] {
        REG_GRADIENT_GAIN = 3'd0,
        REG_MIN_SLOPE     = 3'd1,
        REG_FACING_X      = 3'd2,
        REG_FACING_Y      = 3'd3,
        REG_SPREAD_ANGLE  = 3'd4,
        REG_RAMP_GAIN     = 3'd5,
        REG_INVERT_MASK   = 3'd6
    } reg_idx_t;

    localparam logic [31:0] GRADIENT_GAIN_RST = 32'd65536;
    localparam logic [16:0] MIN_SLOPE_RST     = 17'd3277;
    localparam logic [15:0] FACING_X_RST      = 16'h0000;
    localparam logic [15:0] FACING_Y_RST      = 16'h8000;
    localparam logic [15:0] SPREAD_ANGLE_RST  = 16'd10923;
    localparam logic [23:0] RAMP_GAIN_RST     = 24'd1310663;

    // square root state: remainder and partial root
    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] root;
    } sqrt_st_t;

    // restoring divider state
    typedef struct packed {
        logic [16:0] rem;
        logic [31:0] num;
        logic [15:0] den;
        logic [17:0] quo;
    } div_st_t;

    typedef struct packed {
        logic signed [26:0] x;
        logic signed [26:0] y;
        logic signed [16:0] z;
    } cordic_st_t;

    // atan(2^-i) in units of pi/32768
    function automatic logic signed [16:0] atan_entry(input int i);
        logic signed [16:0] a;
        case (i)
            0:       a = 17'sd8192;
            1:       a = 17'sd4836;
            2:       a = 17'sd2555;
            3:       a = 17'sd1297;
            4:       a = 17'sd651;
            5:       a = 17'sd326;
            6:       a = 17'sd163;
            7:       a = 17'sd81;
            8:       a = 17'sd41;
            9:       a = 17'sd20;
            10:      a = 17'sd10;
            11:      a = 17'sd5;
            12:      a = 17'sd3;
            13:      a = 17'sd1;
            default: a = 17'sd0;
        endcase
        return a;
    endfunction

    // one digit of the integer square root, trial bit 2^(30-2k)
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input int k);
        logic [32:0] b;
        logic [32:0] t;
        sqrt_st_t o;
        b = 33'(1) << (30 - 2 * k);
        t = s.root + b;
        o = s;
        if (s.rem >= t)
        begin
            o.rem  = s.rem - t;
            o.root = (s.root >> 1) + b;
        end
        else
        begin
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // one quotient bit j
    function automatic div_st_t div_step(input div_st_t s, input int j);
        logic [16:0] t;
        div_st_t o;
        t = {s.rem[15:0], s.num[j]};
        o = s;
        if (t >= {1'b0, s.den})
        begin
            o.rem    = t - {1'b0, s.den};
            o.quo[j] = 1'b1;
        end
        else
        begin
            o.rem = t;
        end
        return o;
    endfunction

    // arithmetic shift that truncates toward zero
    function automatic logic signed [26:0] shr0(input logic signed [26:0] v, input int s);
        logic signed [26:0] m;
        m = -v;
        return v[26] ? -(m >>> s) : (v >>> s);
    endfunction

    function automatic cordic_st_t cordic_step(input cordic_st_t s, input int i);
        cordic_st_t o;
        o = s;
        if (s.y > 0)
        begin
            o.x = s.x + shr0(s.y, i);
            o.y = s.y - shr0(s.x, i);
            o.z = s.z + atan_entry(i);
        end
        else if (s.y < 0)
        begin
            o.x = s.x - shr0(s.y, i);
            o.y = s.y + shr0(s.x, i);
            o.z = s.z - atan_entry(i);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/slope_aspect_mask_top.sv
// slope aspect mask: one beat per pixel carries the eight neighbor heights of a
// Sobel window; one beat comes out per pixel with the 16-bit selection strength.
// both channels use valid/stall; a beat moves on a rising edge with valid high
// and stall low. configuration is an APB-style port, registers at 4*index; the
// user must write them only while no pixel is in flight (the block does not
// enforce this). throughput: one beat per cycle unless the output stalls;
// the pipeline has 45 register stages (sobel, gain multiply, flatness
// squares, normalize, dot product, square root, divider, arccos square root,
// 14-step cordic, ramp multiply, output register).
// a stalled output beat freezes every stage at once; in_stall rises only while
// a finished beat is held in the output register, so nothing is lost or
// repeated. reset clears all valid bits and loads the register defaults;
// payload registers are not reset.
`default_nettype none

module slope_aspect_mask_top #(
    parameter int HEIGHT_BITS = sam_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // pixel input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] height_up_left,
    input  wire logic [15:0] height_up,
    input  wire logic [15:0] height_up_right,
    input  wire logic [15:0] height_left,
    input  wire logic [15:0] height_right,
    input  wire logic [15:0] height_down_left,
    input  wire logic [15:0] height_down,
    input  wire logic [15:0] height_down_right,
    // mask output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      mask_value,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sam_pkg::*;

    localparam logic [15:0] HMASK =
        (HEIGHT_BITS >= 16) ? 16'hFFFF : 16'((1 << HEIGHT_BITS) - 1);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [31:0]        gradient_gain_reg;
    logic [16:0]        min_slope_reg;
    logic signed [15:0] facing_x_reg;
    logic signed [15:0] facing_y_reg;
    logic [15:0]        spread_angle_reg;
    logic [23:0]        ramp_gain_reg;
    logic               invert_mask_reg;
    reg_idx_t           cfg_idx;

    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gradient_gain_reg <= GRADIENT_GAIN_RST;
            min_slope_reg     <= MIN_SLOPE_RST;
            facing_x_reg      <= FACING_X_RST;
            facing_y_reg      <= FACING_Y_RST;
            spread_angle_reg  <= SPREAD_ANGLE_RST;
            ramp_gain_reg     <= RAMP_GAIN_RST;
            invert_mask_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                REG_GRADIENT_GAIN: gradient_gain_reg <= pwdata;
                REG_MIN_SLOPE:     min_slope_reg     <= pwdata[16:0];
                REG_FACING_X:      facing_x_reg      <= pwdata[15:0];
                REG_FACING_Y:      facing_y_reg      <= pwdata[15:0];
                REG_SPREAD_ANGLE:  spread_angle_reg  <= pwdata[15:0];
                REG_RAMP_GAIN:     ramp_gain_reg     <= pwdata[23:0];
                REG_INVERT_MASK:   invert_mask_reg   <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GRADIENT_GAIN: prdata = gradient_gain_reg;
            REG_MIN_SLOPE:     prdata = {15'b0, min_slope_reg};
            REG_FACING_X:      prdata = {16'b0, facing_x_reg};
            REG_FACING_Y:      prdata = {16'b0, facing_y_reg};
            REG_SPREAD_ANGLE:  prdata = {16'b0, spread_angle_reg};
            REG_RAMP_GAIN:     prdata = {8'b0, ramp_gain_reg};
            REG_INVERT_MASK:   prdata = {31'b0, invert_mask_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // global pipeline enable: everything advances unless the output
    // register holds a beat the receiver is stalling
    // ---------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------------------------------------------------------
    // stage 1: sobel sums, split into magnitude and downhill sign
    // ---------------------------------------------------------------
    logic [17:0]        sum_r, sum_l, sum_d, sum_u;
    logic signed [18:0] dx_c, dy_c;
    logic               v1_reg;
    logic [17:0]        adx1_reg, ady1_reg;
    logic               negx1_reg, negy1_reg;

    always_comb
    begin
        sum_r = {2'b0, height_up_right & HMASK} + {1'b0, height_right & HMASK, 1'b0}
              + {2'b0, height_down_right & HMASK};
        sum_l = {2'b0, height_up_left & HMASK} + {1'b0, height_left & HMASK, 1'b0}
              + {2'b0, height_down_left & HMASK};
        sum_d = {2'b0, height_down_left & HMASK} + {1'b0, height_down & HMASK, 1'b0}
              + {2'b0, height_down_right & HMASK};
        sum_u = {2'b0, height_up_left & HMASK} + {1'b0, height_up & HMASK, 1'b0}
              + {2'b0, height_up_right & HMASK};
        dx_c  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        dy_c  = $signed({1'b0, sum_d}) - $signed({1'b0, sum_u});
    end

    // ---------------------------------------------------------------
    // stage 2: scale by gradient gain
    // stage 3: flatness squares, larger component
    // stage 4: flatness compare, leading-one position
    // stage 5: normalize so the larger component lies in [2^14, 2^15)
    // ---------------------------------------------------------------
    logic        v2_reg, v3_reg, v4_reg, v5_reg;
    logic [49:0] mx2_reg, my2_reg, mx3_reg, my3_reg, big3_reg, mx4_reg, my4_reg;
    logic        negx2_reg, negy2_reg, negx3_reg, negy3_reg;
    logic        negx4_reg, negy4_reg, negx5_reg, negy5_reg;
    logic        zero3_reg, small3_reg;
    logic [35:0] sqx3_reg, sqy3_reg;
    logic [33:0] msq3_reg;
    logic        flat4_reg, flat5_reg;
    logic        shl4_reg;
    logic [5:0]  sh4_reg;
    logic [14:0] nx5_reg, ny5_reg;
    logic [5:0]  msb_c;

    always_comb
    begin
        msb_c = '0;
        for (int i = 0; i < 50; i++)
        begin
            if (big3_reg[i])
            begin
                msb_c = 6'(i);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 6: signed unit vector times facing, squares for length
    // stage 7: dot product and squared length
    // ---------------------------------------------------------------
    logic               v6_reg, v7_reg;
    logic               flat6_reg, flat7_reg;
    logic signed [15:0] ux_c, uy_c;
    logic signed [31:0] px6_reg, py6_reg;
    logic [29:0]        qx6_reg, qy6_reg;
    logic signed [32:0] dot_c;
    logic [31:0]        adot7_reg;
    logic               dneg7_reg;
    logic [31:0]        rad7_reg;

    assign ux_c  = negx5_reg ? -$signed({1'b0, nx5_reg}) : $signed({1'b0, nx5_reg});
    assign uy_c  = negy5_reg ? -$signed({1'b0, ny5_reg}) : $signed({1'b0, ny5_reg});
    assign dot_c = 33'(px6_reg) + 33'(py6_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: downhill is the negated sobel sum
            adx1_reg  <= dx_c[18] ? 18'(-dx_c) : dx_c[17:0];
            ady1_reg  <= dy_c[18] ? 18'(-dy_c) : dy_c[17:0];
            negx1_reg <= !dx_c[18] && (dx_c != '0);
            negy1_reg <= !dy_c[18] && (dy_c != '0);
            // stage 2
            mx2_reg   <= 50'(adx1_reg) * 50'(gradient_gain_reg);
            my2_reg   <= 50'(ady1_reg) * 50'(gradient_gain_reg);
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            // stage 3
            zero3_reg  <= (mx2_reg == '0) && (my2_reg == '0);
            small3_reg <= (mx2_reg[49:18] == '0) && (my2_reg[49:18] == '0);
            sqx3_reg   <= mx2_reg[17:0] * mx2_reg[17:0];
            sqy3_reg   <= my2_reg[17:0] * my2_reg[17:0];
            msq3_reg   <= min_slope_reg * min_slope_reg;
            big3_reg   <= (mx2_reg > my2_reg) ? mx2_reg : my2_reg;
            mx3_reg    <= mx2_reg;
            my3_reg    <= my2_reg;
            negx3_reg  <= negx2_reg;
            negy3_reg  <= negy2_reg;
            // stage 4: a zero gradient is always flat
            flat4_reg <= zero3_reg
                      || (small3_reg && ({1'b0, sqx3_reg} + {1'b0, sqy3_reg} < 37'(msq3_reg)));
            shl4_reg  <= msb_c < 6'd14;
            sh4_reg   <= (msb_c < 6'd14) ? 6'd14 - msb_c : msb_c - 6'd14;
            mx4_reg   <= mx3_reg;
            my4_reg   <= my3_reg;
            negx4_reg <= negx3_reg;
            negy4_reg <= negy3_reg;
            // stage 5: right shifts truncate each component
            nx5_reg   <= shl4_reg ? 15'(mx4_reg << sh4_reg) : 15'(mx4_reg >> sh4_reg);
            ny5_reg   <= shl4_reg ? 15'(my4_reg << sh4_reg) : 15'(my4_reg >> sh4_reg);
            negx5_reg <= negx4_reg;
            negy5_reg <= negy4_reg;
            flat5_reg <= flat4_reg;
            // stage 6
            px6_reg   <= ux_c * facing_x_reg;
            py6_reg   <= uy_c * facing_y_reg;
            qx6_reg   <= nx5_reg * nx5_reg;
            qy6_reg   <= ny5_reg * ny5_reg;
            flat6_reg <= flat5_reg;
            // stage 7
            adot7_reg <= dot_c[32] ? 32'(-dot_c) : dot_c[31:0];
            dneg7_reg <= dot_c[32];
            rad7_reg  <= 32'(qx6_reg) + 32'(qy6_reg);
            flat7_reg <= flat6_reg;
        end
    end

    // ---------------------------------------------------------------
    // vector length, 8 stages
    // ---------------------------------------------------------------
    typedef struct packed {
        logic        flat;
        logic        dneg;
        logic [31:0] adot;
    } len_side_t;

    len_side_t   len_side_in, len_side_out;
    logic        len_valid;
    logic [15:0] len_root;

    assign len_side_in = '{flat: flat7_reg, dneg: dneg7_reg, adot: adot7_reg};

    sam_isqrt #(
        .SIDE_W ($bits(len_side_t))
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rad    (rad7_reg),
        .in_side   (len_side_in),
        .out_valid (len_valid),
        .out_root  (len_root),
        .out_side  (len_side_out)
    );

    // ---------------------------------------------------------------
    // |dot| / length, 9 stages
    // ---------------------------------------------------------------
    typedef struct packed {
        logic flat;
        logic dneg;
    } div_side_t;

    div_side_t   div_side_in, div_side_out;
    logic        div_valid;
    logic [17:0] div_quo;

    assign div_side_in = '{flat: len_side_out.flat, dneg: len_side_out.dneg};

    sam_div #(
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (len_valid),
        .in_num    (len_side_out.adot),
        .in_den    (len_root),
        .in_side   (div_side_in),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side_out)
    );

    // ---------------------------------------------------------------
    // stage a: clamp alignment to one; stage b: square; stage c: 1 - a^2
    // ---------------------------------------------------------------
    logic        va_reg, vb_reg, vc_reg;
    logic [15:0] ama_reg, amb_reg, amc_reg;
    logic        anega_reg, anegb_reg, anegc_reg;
    logic        flata_reg, flatb_reg, flatc_reg;
    logic [30:0] sqb_reg;
    logic [31:0] radc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= div_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ama_reg   <= (div_quo > 18'd32768) ? 16'd32768 : div_quo[15:0];
            // a zero quotient counts as non-negative
            anega_reg <= div_side_out.dneg && (div_quo != '0);
            flata_reg <= div_side_out.flat;
            sqb_reg   <= 31'(ama_reg) * 31'(ama_reg);
            amb_reg   <= ama_reg;
            anegb_reg <= anega_reg;
            flatb_reg <= flata_reg;
            radc_reg  <= 32'(1 << 30) - 32'(sqb_reg);
            amc_reg   <= amb_reg;
            anegc_reg <= anegb_reg;
            flatc_reg <= flatb_reg;
        end
    end

    // ---------------------------------------------------------------
    // sine term, 8 stages
    // ---------------------------------------------------------------
    typedef struct packed {
        logic        flat;
        logic        aneg;
        logic [15:0] am;
    } sin_side_t;

    sin_side_t   sin_side_in, sin_side_out;
    logic        sin_valid;
    logic [15:0] sin_root;

    assign sin_side_in = '{flat: flatc_reg, aneg: anegc_reg, am: amc_reg};

    sam_isqrt #(
        .SIDE_W ($bits(sin_side_t))
    ) u_sin_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc_reg),
        .in_rad    (radc_reg),
        .in_side   (sin_side_in),
        .out_valid (sin_valid),
        .out_root  (sin_root),
        .out_side  (sin_side_out)
    );

    // ---------------------------------------------------------------
    // atan2(sine, |alignment|), 7 stages
    // ---------------------------------------------------------------
    typedef struct packed {
        logic flat;
        logic aneg;
    } cor_side_t;

    cor_side_t          cor_side_in, cor_side_out;
    logic               cor_valid;
    logic signed [16:0] cor_z;

    assign cor_side_in = '{flat: sin_side_out.flat, aneg: sin_side_out.aneg};

    sam_cordic #(
        .SIDE_W ($bits(cor_side_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sin_valid),
        .in_x      (sin_side_out.am),
        .in_y      (sin_root),
        .in_side   (cor_side_in),
        .out_valid (cor_valid),
        .out_z     (cor_z),
        .out_side  (cor_side_out)
    );

    // ---------------------------------------------------------------
    // stage d: angle and offset from spread; stage e: ramp multiply;
    // output register: bias, clamp, flat override, invert
    // ---------------------------------------------------------------
    logic               vd_reg, ve_reg;
    logic               flatd_reg, flate_reg;
    logic [14:0]        zc_c;
    logic [16:0]        ang_c;
    logic signed [17:0] diffd_reg;
    logic signed [42:0] prode_reg;
    logic signed [43:0] ramp_c;
    logic [15:0]        mask_c;
    logic [15:0]        mask_value_reg;

    always_comb
    begin
        if (cor_z < 0)
        begin
            zc_c = '0;
        end
        else if (cor_z > 17'sd16384)
        begin
            zc_c = 15'd16384;
        end
        else
        begin
            zc_c = cor_z[14:0];
        end
        // obtuse angle for negative alignment
        ang_c = cor_side_out.aneg ? 17'd32768 - 17'(zc_c) : 17'(zc_c);
    end

    always_comb
    begin
        ramp_c = 44'(prode_reg) + 44'sd2147483648;
        if (flate_reg || ramp_c[43])
        begin
            mask_c = '0;
        end
        else if (ramp_c[42:32] != '0)
        begin
            mask_c = 16'hFFFF;
        end
        else
        begin
            mask_c = ramp_c[31:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg        <= cor_valid;
            ve_reg        <= vd_reg;
            out_valid_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diffd_reg      <= $signed({2'b0, spread_angle_reg}) - $signed({1'b0, ang_c});
            flatd_reg      <= cor_side_out.flat;
            prode_reg      <= diffd_reg * $signed({1'b0, ramp_gain_reg});
            flate_reg      <= flatd_reg;
            mask_value_reg <= invert_mask_reg ? ~mask_c : mask_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mask_value = mask_value_reg;

endmodule

`default_nettype wire

>>> rtl/core/sam_isqrt.sv
`default_nettype none

module sam_isqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       in_rad,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [15:0]            out_root,
    output logic [SIDE_W-1:0]      out_side
);
    import sam_pkg::*;

    localparam int STAGES = 8;

    sqrt_st_t          st_reg    [0:STAGES];
    logic [SIDE_W-1:0] side_reg  [0:STAGES];
    logic              valid_reg [0:STAGES];

    always_comb
    begin
        st_reg[0].rem  = {1'b0, in_rad};
        st_reg[0].root = '0;
        side_reg[0]    = in_side;
        valid_reg[0]   = in_valid;
    end

    // two root digits per stage
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g+1]   <= sqrt_step(sqrt_step(st_reg[g], 2 * g), 2 * g + 1);
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_root  = st_reg[STAGES].root[15:0];
    assign out_side  = side_reg[STAGES];

endmodule

`default_nettype wire

>>> rtl/core/sam_div.sv
`default_nettype none

module sam_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       in_num,
    input  wire logic [15:0]       in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [17:0]            out_quo,
    output logic [SIDE_W-1:0]      out_side
);
    import sam_pkg::*;

    localparam int QBITS  = 18;
    localparam int STAGES = QBITS / 2;

    div_st_t           st_reg    [0:STAGES];
    logic [SIDE_W-1:0] side_reg  [0:STAGES];
    logic              valid_reg [0:STAGES];

    // quotient stays below 2^18 since the divisor is at least 2^14
    always_comb
    begin
        st_reg[0].rem = 17'(in_num[31:QBITS]);
        st_reg[0].num = in_num;
        st_reg[0].den = in_den;
        st_reg[0].quo = '0;
        side_reg[0]   = in_side;
        valid_reg[0]  = in_valid;
    end

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g+1]   <= div_step(div_step(st_reg[g], QBITS - 1 - 2 * g),
                                          QBITS - 2 - 2 * g);
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_quo   = st_reg[STAGES].quo;
    assign out_side  = side_reg[STAGES];

endmodule

`default_nettype wire

>>> rtl/core/sam_cordic.sv
`default_nettype none

module sam_cordic #(
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [15:0]       in_x,
    input  wire logic [15:0]       in_y,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic signed [16:0]     out_z,
    output logic [SIDE_W-1:0]      out_side
);
    import sam_pkg::*;

    localparam int ITERS  = 14;
    localparam int STAGES = ITERS / 2;

    cordic_st_t        st_reg    [0:STAGES];
    logic [SIDE_W-1:0] side_reg  [0:STAGES];
    logic              valid_reg [0:STAGES];

    // inputs scaled by 256
    always_comb
    begin
        st_reg[0].x  = $signed({3'b0, in_x, 8'b0});
        st_reg[0].y  = $signed({3'b0, in_y, 8'b0});
        st_reg[0].z  = '0;
        side_reg[0]  = in_side;
        valid_reg[0] = in_valid;
    end

    // a zero residual holds the vector for the remaining iterations
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g+1]   <= cordic_step(cordic_step(st_reg[g], 2 * g), 2 * g + 1);
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_z     = st_reg[STAGES].z;
    assign out_side  = side_reg[STAGES];

endmodule

`default_nettype wire

>>> rtl/core/sam_checker.sv
`default_nettype none

module sam_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] mask_value,
    input wire logic        pready
);

    // a held output beat keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mask_value))
        else $error("output beat changed under stall");

    // input backpressure only comes from a stalled output beat
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output beat right after reset");

    // an empty output register never holds off the input
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("stall with empty output register");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind slope_aspect_mask_top sam_checker u_sam_checker (.*);

`default_nettype wire
